[src/assert_macros.svh]
// Assertion helpers for the checker file.
// Each macro samples on the rising edge of clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define HPE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define HPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/hpe_pkg.sv]
`timescale 1ns / 1ps

package hpe_pkg;

	// Number of coefficients in use and fractional bits of the Q format
	localparam int NUM_COEFFS = 8;
	localparam int FRAC_BITS  = 16;

	// Register file and word widths
	localparam int REG_COUNT = 8;
	localparam int REG_IDX_W = $clog2(REG_COUNT);
	localparam int CFG_IDX_W = REG_IDX_W + 1;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SUM_W     = PROD_W + 1;

	// Horner steps and the register that seeds the accumulator
	localparam int STEPS = NUM_COEFFS - 1;
	localparam int FIRST = REG_COUNT - NUM_COEFFS;

	// Half an LSB of the result, zero when there are no fraction bits
	localparam logic signed [PROD_W-1:0] ROUND_HALF =
		(PROD_W'(64'sd1) <<< FRAC_BITS) >>> 1;

	// Saturation limits in the widened sum
	localparam logic signed [SUM_W-1:0] SAT_MAX =
		SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
	localparam logic signed [SUM_W-1:0] SAT_MIN =
		-SAT_MAX - SUM_W'(1);

	typedef logic signed [DATA_W-1:0] word_t;

	// One item in flight between Horner steps
	typedef struct packed {
		logic  valid;
		logic  ovf;
		word_t x;
		word_t acc;
	} hpe_lane_t;

endpackage

[src/horner_polynomial_evaluator_core.sv]
`timescale 1ns / 1ps

// Horner polynomial evaluator, signed Q16.16.
// Input channel s_*: one word per point, s_tdata = arg_x.
// Output channel m_*: one word per input, m_tdata = value_y (saturated),
// m_tuser = overflow (set if any Horner step clamped for this word).
// Coefficients sit in eight registers written through cfg_we / cfg_index /
// cfg_data, index 0 = x^7 down to index 7 = constant; indexes 8 and up are
// ignored. Write them only while no word is in flight.
// Each Horner step has a multiply stage and a round/add/saturate stage.
// Throughput is one word per cycle while the output is not stalled; the
// 32x32 multiplier of each step sets the stage depth.
// Reset clears all coefficients to zero and empties the pipeline.
// When the receiver stalls with a result pending, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
module horner_polynomial_evaluator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hpe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hpe_pkg::DATA_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [hpe_pkg::DATA_W-1:0]     s_tdata,  // [31:0] arg_x
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [hpe_pkg::DATA_W-1:0]     m_tdata,  // [31:0] value_y
	output logic                           m_tuser   // [0] overflow
);
	import hpe_pkg::*;

	word_t     coef_q [REG_COUNT];
	hpe_lane_t lane [STEPS+1];
	logic      adv;

	// Coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
			coef_q[cfg_index[REG_IDX_W-1:0]] <= word_t'(cfg_data);
		end
	end

	// Whole pipeline moves unless a result waits at the output
	assign adv      = !(m_tvalid && !m_tready);
	assign s_tready = adv;

	// Seed: accumulator starts at the highest coefficient in use
	always_comb begin
		lane[0].valid = s_tvalid;
		lane[0].ovf   = 1'b0;
		lane[0].x     = word_t'(s_tdata);
		lane[0].acc   = coef_q[FIRST];
	end

	generate
		if (STEPS == 0) begin : g_const
			logic  valid_s1;
			word_t acc_s1;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s1 <= 1'b0;
				end else if (adv) begin
					valid_s1 <= lane[0].valid;
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					acc_s1 <= lane[0].acc;
				end
			end

			assign m_tvalid = valid_s1;
			assign m_tdata  = acc_s1;
			assign m_tuser  = 1'b0;
		end else begin : g_steps
			for (genvar k = 0; k < STEPS; k++) begin : g_step
				hpe_step u_step (
					.clk      (clk),
					.arst_n   (arst_n),
					.adv      (adv),
					.coef     (coef_q[FIRST + k + 1]),
					.lane_in  (lane[k]),
					.lane_out (lane[k+1])
				);
			end

			assign m_tvalid = lane[STEPS].valid;
			assign m_tdata  = lane[STEPS].acc;
			assign m_tuser  = lane[STEPS].ovf;
		end
	endgenerate

endmodule

[src/hpe_step.sv]
`timescale 1ns / 1ps

// One Horner step in two register stages:
//   s1: exact product acc * x
//   s2: round, add the coefficient, saturate to 32 bits
module hpe_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  hpe_pkg::word_t    coef,
	input  hpe_pkg::hpe_lane_t lane_in,
	output hpe_pkg::hpe_lane_t lane_out
);
	import hpe_pkg::*;

	logic                      valid_s1;
	logic                      ovf_s1;
	word_t                     x_s1;
	logic signed [PROD_W-1:0]  prod_s1;

	logic signed [PROD_W-1:0]  rnd;
	logic signed [SUM_W-1:0]   sum;
	word_t                     sat;
	logic                      sat_hit;

	logic                      valid_s2;
	logic                      ovf_s2;
	word_t                     x_s2;
	word_t                     acc_s2;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= lane_in.valid;
			valid_s2 <= valid_s1;
		end
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= PROD_W'(lane_in.acc) * PROD_W'(lane_in.x);
			x_s1    <= lane_in.x;
			ovf_s1  <= lane_in.ovf;
		end
	end

	// Round to nearest (ties up), add coefficient, clamp
	always_comb begin
		rnd     = (prod_s1 + ROUND_HALF) >>> FRAC_BITS;
		sum     = SUM_W'(rnd) + SUM_W'(coef);
		sat_hit = 1'b0;
		if (sum > SAT_MAX) begin
			sat     = word_t'(SAT_MAX[DATA_W-1:0]);
			sat_hit = 1'b1;
		end else if (sum < SAT_MIN) begin
			sat     = word_t'(SAT_MIN[DATA_W-1:0]);
			sat_hit = 1'b1;
		end else begin
			sat = sum[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s2 <= sat;
			x_s2   <= x_s1;
			ovf_s2 <= ovf_s1 | sat_hit;
		end
	end

	assign lane_out = '{valid: valid_s2, ovf: ovf_s2, x: x_s2, acc: acc_s2};

endmodule

[src/hpe_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the evaluator core
module hpe_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [hpe_pkg::DATA_W-1:0]    s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [hpe_pkg::DATA_W-1:0]    m_tdata,
	input logic                          m_tuser
);
	// A stalled result holds its word
	`HPE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")

	// With no result pending the pipeline must take input
	`HPE_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

	// Taking the output frees the pipeline in the same cycle
	`HPE_ASSERT_NOW(a_ready_on_take, m_tvalid && m_tready, s_tready, "input stalled while output taken")

	// A blocked output blocks the input
	`HPE_ASSERT_NOW(a_stall_back, m_tvalid && !m_tready, !s_tready, "input taken while output blocked")

endmodule

bind horner_polynomial_evaluator_core hpe_checker u_hpe_checker (.*);
